// ----- design/mix3_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mix3_pkg
// Shared types, constants and the shift-add volume function of the
// three-channel PCM mixer.
// ----------------------------------------------------------------------------
package mix3_pkg;

  localparam int SAMPLE_W = 16;
  localparam int VOL_W    = 5;
  localparam int MASK_W   = 3;
  localparam int NUM_CH   = 3;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int MIX_W    = SAMPLE_W + 2;
  localparam int CH_W     = 2;

  localparam logic signed [SAMPLE_W-1:0] ZC_LIMIT    = 16'sd50;
  localparam logic [VOL_W-1:0]           VOL_RESET   = 5'd16;
  localparam logic [MASK_W-1:0]          MIXEN_RESET = 3'd0;
  localparam logic [CH_W-1:0]            LAST_CH     = 2'd2;

  typedef enum logic [1:0] {
    REG_TARGET0 = 2'd0,
    REG_TARGET1 = 2'd1,
    REG_TARGET2 = 2'd2,
    REG_MIX_EN  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_PICK,
    ST_MUL,
    ST_COMB,
    ST_FSCALE,
    ST_OUT
  } state_t;

  // Bits 0..3 add s>>4, s>>3, s>>2, s>>1; bit 4 passes s and overrides the rest
  function automatic logic signed [SAMPLE_W-1:0] scale_sample(
    input logic signed [SAMPLE_W-1:0] s,
    input logic [VOL_W-1:0]           vol
  );
    logic signed [SAMPLE_W-1:0] acc;
    acc = '0;
    if (vol[0]) acc = acc + (s >>> 4);
    if (vol[1]) acc = acc + (s >>> 3);
    if (vol[2]) acc = acc + (s >>> 2);
    if (vol[3]) acc = acc + (s >>> 1);
    if (vol[4]) acc = s;
    return acc;
  endfunction

endpackage

// ----- design/three_channel_pcm_mixer_with_volume.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_channel_pcm_mixer_with_volume
// Mixes three PCM channels into one sample with per-channel volume and
// a shared multiplier for the a+b-ab pair mix.
//
//   port group   direction   handshake          payload
//   input word   in          in_valid/in_stall  sample_a/b/c, active_mask
//   output word  out         out_valid/out_stall mixed_sample
//   registers    in/out      APB psel/penable   paddr, pwdata, prdata
//
// One word at a time, and a word also waits out any output stall. With one or
// two channels active the scaler steps over all three channels either way. The
// single 16x16 multiplier and the single shift-add scaler are reused by a small
// sequencer.
// in_stall is high whenever the sequencer is busy. rst (synchronous) returns
// volumes to 16, mix enables to 0 and empties the output register.
// ----------------------------------------------------------------------------
module three_channel_pcm_mixer_with_volume
  import mix3_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] sample_a,
  input  logic signed [SAMPLE_W-1:0] sample_b,
  input  logic signed [SAMPLE_W-1:0] sample_c,
  input  logic [MASK_W-1:0]          active_mask,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] mixed_sample,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  state_t state, state_next;

  logic [VOL_W-1:0]  target_vol [NUM_CH];
  logic [VOL_W-1:0]  applied_volume [NUM_CH];
  logic [MASK_W-1:0] mix_enables;

  logic signed [SAMPLE_W-1:0] samp [NUM_CH];
  logic signed [SAMPLE_W-1:0] v [NUM_CH];
  logic [MASK_W-1:0]          act_mask;
  logic [CH_W-1:0]            ch;

  logic signed [SAMPLE_W-1:0] x, y, res;
  logic                       wx, wy, halve, second;
  logic signed [PROD_W-1:0]   prod;

  logic                       accept, out_free, cfg_wr, zc, single;
  reg_idx_t                   wr_idx;
  logic signed [SAMPLE_W-1:0] sc_in, sc_out, cur_s;
  logic [VOL_W-1:0]           sc_vol;
  logic signed [MIX_W-1:0]    lin, pr, mres;
  logic signed [SAMPLE_W-1:0] mix_out;

  assign pready   = 1'b1;
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign wr_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      target_vol[0] <= VOL_RESET;
      target_vol[1] <= VOL_RESET;
      target_vol[2] <= VOL_RESET;
      mix_enables   <= MIXEN_RESET;
    end else if (cfg_wr) begin
      case (wr_idx)
        REG_TARGET0: target_vol[0] <= pwdata[VOL_W-1:0];
        REG_TARGET1: target_vol[1] <= pwdata[VOL_W-1:0];
        REG_TARGET2: target_vol[2] <= pwdata[VOL_W-1:0];
        REG_MIX_EN:  mix_enables   <= pwdata[MASK_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[ADDR_W-1:2]))
      REG_TARGET0: prdata = {{(DATA_W-VOL_W){1'b0}}, target_vol[0]};
      REG_TARGET1: prdata = {{(DATA_W-VOL_W){1'b0}}, target_vol[1]};
      REG_TARGET2: prdata = {{(DATA_W-VOL_W){1'b0}}, target_vol[2]};
      REG_MIX_EN:  prdata = {{(DATA_W-MASK_W){1'b0}}, mix_enables};
      default:     prdata = '0;
    endcase
  end

  // Shared shift-add scaler
  assign cur_s = samp[ch];
  assign zc    = (cur_s < ZC_LIMIT) && (cur_s > -ZC_LIMIT);

  always_comb begin
    if (state == ST_FSCALE) begin
      sc_in  = x;
      sc_vol = target_vol[0];
    end else begin
      sc_in  = cur_s;
      sc_vol = zc ? target_vol[ch] : applied_volume[ch];
    end
  end

  assign sc_out = scale_sample(sc_in, sc_vol);

  // Pair mix from the registered product; sign test uses the unweighted operands
  assign lin = (wx ? MIX_W'(x) : '0) + (wy ? MIX_W'(y) : '0);
  assign pr  = (wx && wy) ? MIX_W'(prod[PROD_W-1:SAMPLE_W-1]) : '0;
  assign mres    = (x[SAMPLE_W-1] && y[SAMPLE_W-1]) ? lin + pr : lin - pr;
  assign mix_out = halve ? mres[SAMPLE_W:1] : mres[SAMPLE_W-1:0];

  assign single = (act_mask == 3'b001) || (act_mask == 3'b010) || (act_mask == 3'b100);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (active_mask == '0)       state_next = ST_OUT;
          else if (active_mask == '1)  state_next = ST_MUL;
          else                         state_next = ST_SCALE;
        end
      end
      ST_SCALE:  if (ch == LAST_CH) state_next = ST_PICK;
      ST_PICK:   state_next = single ? ST_OUT : ST_MUL;
      ST_MUL:    state_next = ST_COMB;
      ST_COMB: begin
        if (act_mask != '1)  state_next = ST_OUT;
        else if (second)     state_next = ST_FSCALE;
        else                 state_next = ST_MUL;
      end
      ST_FSCALE: state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Latched volumes
  always_ff @(posedge clk) begin
    if (rst) begin
      applied_volume[0] <= VOL_RESET;
      applied_volume[1] <= VOL_RESET;
      applied_volume[2] <= VOL_RESET;
    end else if (state == ST_SCALE && act_mask[ch] && zc) begin
      applied_volume[ch] <= target_vol[ch];
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          samp[0]  <= sample_a;
          samp[1]  <= sample_b;
          samp[2]  <= sample_c;
          act_mask <= active_mask;
          ch       <= '0;
          res      <= '0;
          x        <= sample_a;
          y        <= sample_b;
          wx       <= mix_enables[0];
          wy       <= mix_enables[1];
          halve    <= 1'b1;
          second   <= 1'b0;
        end
      end
      ST_SCALE: begin
        v[ch] <= sc_out;
        ch    <= ch + 1'b1;
      end
      ST_PICK: begin
        res   <= act_mask[0] ? v[0] : (act_mask[1] ? v[1] : v[2]);
        x     <= act_mask[0] ? v[0] : v[1];
        y     <= act_mask[2] ? v[2] : v[1];
        wx    <= 1'b1;
        wy    <= 1'b1;
        halve <= 1'b1;
      end
      ST_MUL: prod <= x * y;
      ST_COMB: begin
        res    <= mix_out;
        // Feed the pair mix on with channel 2, no halving this time
        x      <= mix_out;
        y      <= samp[2];
        wx     <= 1'b1;
        wy     <= mix_enables[2];
        halve  <= 1'b0;
        second <= 1'b1;
      end
      ST_FSCALE: res <= sc_out;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) mixed_sample <= res;
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the three-channel PCM mixer. A queue of pending
// words feeds a clocked driver. Each accepted word is run through a local
// mixing predictor that keeps its own volume latches and register copies.
// A clocked monitor compares every output word with the oldest prediction.
// The registers are reprogrammed over APB between phases, once the mixer has
// drained. Directed corner words come first, then random phases, all but the
// last with random idle bursts on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import mix3_pkg::*;

  localparam int QUIET_LIMIT    = 1000;
  localparam int RANDOM_PHASES  = 12;
  localparam int WORDS_PER_PHASE = 163;
  localparam int MAX_REPORTS    = 40;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
    logic signed [SAMPLE_W-1:0] c;
    logic [MASK_W-1:0]          mask;
  } mix_word_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample_a = '0;
  logic signed [SAMPLE_W-1:0] sample_b = '0;
  logic signed [SAMPLE_W-1:0] sample_c = '0;
  logic [MASK_W-1:0]          active_mask = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] mixed_sample;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [ADDR_W-1:0]          paddr = '0;
  logic [DATA_W-1:0]          pwdata = '0;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  // Local copies of the register file and the per-channel volume latches
  logic [VOL_W-1:0]  target_set [NUM_CH];
  logic [VOL_W-1:0]  applied_vol [NUM_CH];
  logic [MASK_W-1:0] mix_en_set;

  mix_word_t                  words_to_send [$];
  logic signed [SAMPLE_W-1:0] mix_due [$];
  mix_word_t                  next_word;
  logic signed [SAMPLE_W-1:0] due_word;
  int                         send_gap;
  int                         hold_left;
  int                         quiet_cycles;
  int                         error_count;
  bit                         bursts_on = 1'b1;

  three_channel_pcm_mixer_with_volume i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_a     (sample_a),
    .sample_b     (sample_b),
    .sample_c     (sample_c),
    .active_mask  (active_mask),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mixed_sample (mixed_sample),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shift-add gain: bits 0..3 add s>>4 .. s>>1, bit 4 passes s untouched
  function automatic logic signed [SAMPLE_W-1:0] vol_scale(
    input logic signed [SAMPLE_W-1:0] s,
    input logic [VOL_W-1:0]           v
  );
    logic signed [SAMPLE_W-1:0] sum;
    sum = '0;
    for (int k = 0; k < 4; k++)
      if (v[k]) sum = sum + (s >>> (4 - k));
    return v[4] ? s : sum;
  endfunction

  // a + b - ab, halved; the product is added when both inputs are negative
  function automatic logic signed [SAMPLE_W-1:0] pcm_pair(
    input longint x,
    input longint y,
    input longint wx,
    input longint wy
  );
    longint lin;
    longint prod;
    longint r;
    lin  = x * wx + y * wy;
    prod = (x * y * wx * wy) >>> 15;
    r    = (x < 0 && y < 0) ? lin + prod : lin - prod;
    r    = r >>> 1;
    return r[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] compute_mix(input mix_word_t w);
    logic signed [SAMPLE_W-1:0] smp [NUM_CH];
    logic signed [SAMPLE_W-1:0] picked [2];
    logic signed [SAMPLE_W-1:0] pair;
    longint                     lin;
    longint                     prod;
    longint                     q;
    int                         n;
    smp = '{w.a, w.b, w.c};
    if (w.mask == 3'b111) begin
      pair = pcm_pair(w.a, w.b, mix_en_set[0], mix_en_set[1]);
      lin  = longint'(pair) + longint'(w.c) * longint'(mix_en_set[2]);
      prod = (longint'(pair) * longint'(w.c) * longint'(mix_en_set[2])) >>> 15;
      q    = (pair < 0 && w.c < 0) ? lin + prod : lin - prod;
      // final gain takes the channel 0 target directly, no latch
      return vol_scale(q[SAMPLE_W-1:0], target_set[0]);
    end
    if (w.mask == '0)
      return '0;
    n = 0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (w.mask[ch]) begin
        // latch the new volume only near a zero crossing
        if (smp[ch] < ZC_LIMIT && smp[ch] > -ZC_LIMIT)
          applied_vol[ch] = target_set[ch];
        if (n < 2)
          picked[n] = vol_scale(smp[ch], applied_vol[ch]);
        n++;
      end
    end
    return (n == 1) ? picked[0] : pcm_pair(picked[0], picked[1], 1, 1);
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_MIX_EN)
      mix_en_set = value[MASK_W-1:0];
    else
      target_set[int'(idx)] = value[VOL_W-1:0];
  endtask

  task automatic program_regs(
    input logic [VOL_W-1:0]  v0,
    input logic [VOL_W-1:0]  v1,
    input logic [VOL_W-1:0]  v2,
    input logic [MASK_W-1:0] en
  );
    write_reg(REG_TARGET0, DATA_W'(v0));
    write_reg(REG_TARGET1, DATA_W'(v1));
    write_reg(REG_TARGET2, DATA_W'(v2));
    write_reg(REG_MIX_EN, DATA_W'(en));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (words_to_send.size() != 0 || in_valid || mix_due.size() != 0);
  endtask

  task automatic queue_word(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b,
    input logic signed [SAMPLE_W-1:0] c,
    input logic [MASK_W-1:0]          mask
  );
    words_to_send.push_back('{a: a, b: b, c: c, mask: mask});
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0, 1:    return SAMPLE_W'(int'($urandom_range(0, 118)) - 59);
      2: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh7fff;
          1:       return 16'sh8000;
          2:       return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [VOL_W-1:0] rand_volume();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return VOL_RESET;
      default: return VOL_W'($urandom_range(0, 31));
    endcase
  endfunction

  // Driver: present queued words, hold while stalled, idle in short bursts
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall)
        mix_due.push_back(compute_mix('{a: sample_a, b: sample_b, c: sample_c,
                                        mask: active_mask}));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (words_to_send.size() > 0) begin
          next_word = words_to_send.pop_front();
          sample_a    <= next_word.a;
          sample_b    <= next_word.b;
          sample_c    <= next_word.c;
          active_mask <= next_word.mask;
          in_valid    <= 1'b1;
          if (bursts_on && $urandom_range(0, 7) == 0)
            send_gap = $urandom_range(1, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output word against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (mix_due.size() == 0) begin
          report_error($sformatf("unexpected output word %0d", mixed_sample));
        end else begin
          due_word = mix_due.pop_front();
          if (mixed_sample !== due_word)
            report_error($sformatf("mixed_sample got %0d want %0d",
                                   mixed_sample, due_word));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (bursts_on && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: give up after a long stretch with no word moving either way
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    error_count = 0;
    quiet_cycles = 0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      target_set[ch]  = VOL_RESET;
      applied_vol[ch] = VOL_RESET;
    end
    mix_en_set = MIXEN_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: full volume everywhere, no three-channel weights
    queue_word(16'sh7fff, 16'sh8000, 16'sd123, 3'b000);
    queue_word(16'sh7fff, 16'sd0, 16'sd0, 3'b001);
    queue_word(16'sd0, 16'sh8000, 16'sd0, 3'b010);
    queue_word(16'sd0, 16'sd0, 16'sd49, 3'b100);
    queue_word(16'sh8000, 16'sh8000, 16'sd0, 3'b011);
    queue_word(16'sh7fff, 16'sd0, 16'sh8000, 3'b101);
    queue_word(16'sd0, -16'sd50, 16'sd50, 3'b110);
    queue_word(16'sh7fff, 16'sh7fff, 16'sh7fff, 3'b111);
    wait_drained();

    program_regs(5'd15, 5'd0, 5'd31, 3'b111);
    // Channel 0 keeps the old gain until a word near zero arrives
    queue_word(-16'sd20000, 16'sd0, 16'sd0, 3'b001);
    queue_word(-16'sd49, 16'sd0, 16'sd0, 3'b001);
    queue_word(-16'sd20000, 16'sd0, 16'sd0, 3'b001);
    queue_word(16'sd0, 16'sd0, 16'sd0, 3'b010);
    queue_word(16'sd0, 16'sh7fff, 16'sd0, 3'b010);
    // Three-channel sum overflows and wraps
    queue_word(16'sh7fff, 16'sh7fff, 16'sh7fff, 3'b111);
    queue_word(16'sh8000, 16'sh8000, 16'sh8000, 3'b111);
    queue_word(-16'sd1, -16'sd1, 16'sd1, 3'b111);
    queue_word(16'sd0, -16'sd30000, -16'sd30000, 3'b110);
    queue_word(16'sd49, -16'sd49, 16'sd0, 3'b011);
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0)
        program_regs('0, '0, '0, '0);
      else if (ph == 1)
        program_regs('1, '1, '1, '1);
      else
        program_regs(rand_volume(), rand_volume(), rand_volume(),
                     MASK_W'($urandom_range(0, 7)));
      // Let the last phase run flat out
      if (ph == RANDOM_PHASES - 1)
        bursts_on = 1'b0;
      for (int i = 0; i < WORDS_PER_PHASE; i++)
        queue_word(rand_sample(), rand_sample(), rand_sample(),
                   MASK_W'($urandom_range(0, 7)));
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/mix3_pkg.sv
design/three_channel_pcm_mixer_with_volume.sv
verif/testbench.sv
